FILE: rtl/core/lqr_pkg.sv
// Shared types, constants and saturating Q32.32 helpers for the LQR trajectory block.
`default_nettype none
package lqr_pkg;

	localparam int MAX_HORIZON = 64;
	localparam int HIDX_W = $clog2(MAX_HORIZON);
	localparam int HCNT_W = $clog2(MAX_HORIZON + 1);

	typedef logic signed [63:0] q_t;

	localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;
	localparam q_t Q_HALF = 64'sh0000_0000_8000_0000;
	localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

	localparam logic [1:0] CFG_STEP_TIME = 2'd0;
	localparam logic [1:0] CFG_CONTROL_WEIGHT = 2'd1;
	localparam logic [1:0] CFG_HORIZON_STEPS = 2'd2;

	typedef struct packed {
		logic en;
		logic [HIDX_W-1:0] addr;
		q_t nk1;
		q_t nk2;
	} gain_wr_t;

	function automatic q_t sadd(input q_t a, input q_t b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? Q_MIN : Q_MAX;
		end
		return q_t'(s[63:0]);
	endfunction

	function automatic q_t ssub(input q_t a, input q_t b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? Q_MIN : Q_MAX;
		end
		return q_t'(s[63:0]);
	endfunction

	function automatic logic [63:0] mag(input q_t x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic q_t with_sign(input logic [63:0] m, input logic neg);
		if (neg) begin
			if (m[63]) begin
				return Q_MIN;
			end
			return q_t'(~m + 64'd1);
		end
		if (m[63]) begin
			return Q_MAX;
		end
		return q_t'(m);
	endfunction

	function automatic q_t port_in(input logic [31:0] v);
		return q_t'({{16{v[31]}}, v, 16'h0000});
	endfunction

	function automatic logic [31:0] port_out(input q_t x);
		logic [47:0] r;
		r = x[63:16];
		if (!r[47] && (r[46:31] != 16'h0000)) begin
			return 32'h7FFF_FFFF;
		end
		if (r[47] && (r[46:31] != 16'hFFFF)) begin
			return 32'h8000_0000;
		end
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lqr_qmul.sv
// Multi-cycle saturating Q32.32 multiplier, one 32x32 partial product a cycle.
`default_nettype none
module lqr_qmul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  lqr_pkg::q_t      a,
	input  lqr_pkg::q_t      b,
	output logic             done,
	output lqr_pkg::q_t      y
);
	import lqr_pkg::*;

	logic [63:0] xm_q, ym_q;
	logic neg_q;
	logic [127:0] acc_q;
	logic [2:0] cnt_q;
	logic busy_q, done_q;
	q_t y_q;
	logic [31:0] xs, ys;
	logic [63:0] pp;
	logic [127:0] pp_sh;

	always_comb begin
		xs = cnt_q[0] ? xm_q[63:32] : xm_q[31:0];
		ys = cnt_q[1] ? ym_q[63:32] : ym_q[31:0];
		pp = xs * ys;
		case (cnt_q)
			3'd0: pp_sh = {64'h0, pp};
			3'd1, 3'd2: pp_sh = {32'h0, pp, 32'h0};
			3'd3: pp_sh = {pp, 64'h0};
			default: pp_sh = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				xm_q <= mag(a);
				ym_q <= mag(b);
				neg_q <= a[63] ^ b[63];
				acc_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					// saturate when the product reaches 2^64 after dropping fraction bits
					y_q <= with_sign((acc_q[127:96] != 32'h0) ?
						64'hFFFF_FFFF_FFFF_FFFF : acc_q[95:32], neg_q);
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					acc_q <= acc_q + pp_sh;
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign y = y_q;

endmodule
`default_nettype wire

FILE: rtl/core/lqr_qdiv.sv
// Radix-2 restoring divider for saturating Q32.32 quotients.
`default_nettype none
module lqr_qdiv (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  lqr_pkg::q_t      n,
	input  lqr_pkg::q_t      d,
	output logic             done,
	output lqr_pkg::q_t      y
);
	import lqr_pkg::*;

	logic [63:0] ym_q, rem_q, lo_q, quo_q;
	logic neg_q, busy_q, done_q;
	logic [5:0] cnt_q;
	q_t y_q;
	logic [63:0] nm, dm;
	logic [64:0] r2;
	logic [63:0] rem_nx, quo_nx;

	always_comb begin
		nm = mag(n);
		dm = mag(d);
		r2 = {rem_q, lo_q[63]};
		if (r2 >= {1'b0, ym_q}) begin
			rem_nx = 64'(r2 - {1'b0, ym_q});
			quo_nx = {quo_q[62:0], 1'b1};
		end else begin
			rem_nx = r2[63:0];
			quo_nx = {quo_q[62:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q <= n[63] ^ d[63];
				if (d == '0) begin
					// zero divisor: zero over zero, else the extreme with the sign of n
					y_q <= (n == '0) ? '0 : (n[63] ? Q_MIN : Q_MAX);
					done_q <= 1'b1;
				end else if ({32'h0, nm[63:32]} >= dm) begin
					y_q <= with_sign(64'hFFFF_FFFF_FFFF_FFFF, n[63] ^ d[63]);
					done_q <= 1'b1;
				end else begin
					ym_q <= dm;
					rem_q <= {32'h0, nm[63:32]};
					lo_q <= {nm[31:0], 32'h0};
					quo_q <= '0;
					cnt_q <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				lo_q <= {lo_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					y_q <= with_sign(quo_nx, neg_q);
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign y = y_q;

endmodule
`default_nettype wire

FILE: rtl/core/lqr_lane.sv
// One axis lane: closed-loop position and velocity update on its own multiplier.
`default_nettype none
module lqr_lane (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  lqr_pkg::q_t      init_p,
	input  lqr_pkg::q_t      init_v,
	input  lqr_pkg::q_t      tgt_p,
	input  lqr_pkg::q_t      tgt_v,
	input  wire logic        go,
	input  lqr_pkg::q_t      nk1,
	input  lqr_pkg::q_t      nk2,
	input  lqr_pkg::q_t      dt,
	input  lqr_pkg::q_t      h,
	output logic             done,
	output lqr_pkg::q_t      pos,
	output lqr_pkg::q_t      vel
);
	import lqr_pkg::*;

	typedef enum logic [2:0] {L_IDLE, L_M1, L_M2, L_M3, L_M4, L_M5} lane_state_t;

	lane_state_t state_q;
	logic issued_q, done_q;
	q_t p_q, v_q, tp_q, tv_q, t_q, u_q;
	q_t opa, opb, prod;
	logic mul_start, mul_done;

	always_comb begin
		case (state_q)
			L_M1: begin opa = nk1; opb = ssub(p_q, tp_q); end
			L_M2: begin opa = nk2; opb = ssub(v_q, tv_q); end
			L_M3: begin opa = dt; opb = v_q; end
			L_M4: begin opa = h; opb = u_q; end
			L_M5: begin opa = dt; opb = u_q; end
			default: begin opa = '0; opb = '0; end
		endcase
		mul_start = (state_q != L_IDLE) && !issued_q;
	end

	lqr_qmul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(opa), .b(opb), .done(mul_done), .y(prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			issued_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				p_q <= init_p;
				v_q <= init_v;
				tp_q <= tgt_p;
				tv_q <= tgt_v;
			end
			if (mul_start) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				L_IDLE: begin
					if (go) begin
						state_q <= L_M1;
					end
				end
				L_M1: begin
					if (mul_done) begin
						t_q <= prod;
						issued_q <= 1'b0;
						state_q <= L_M2;
					end
				end
				L_M2: begin
					if (mul_done) begin
						u_q <= sadd(t_q, prod);
						issued_q <= 1'b0;
						state_q <= L_M3;
					end
				end
				L_M3: begin
					if (mul_done) begin
						t_q <= sadd(p_q, prod);
						issued_q <= 1'b0;
						state_q <= L_M4;
					end
				end
				L_M4: begin
					if (mul_done) begin
						t_q <= sadd(t_q, prod);
						issued_q <= 1'b0;
						state_q <= L_M5;
					end
				end
				L_M5: begin
					if (mul_done) begin
						v_q <= sadd(v_q, prod);
						p_q <= t_q;
						issued_q <= 1'b0;
						done_q <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign pos = p_q;
	assign vel = v_q;

endmodule
`default_nettype wire

FILE: rtl/core/lqr_riccati.sv
// Backward Riccati sequencer: one shared multiplier and divider, writes per-step gains.
`default_nettype none
module lqr_riccati (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [30:0]                   step_time,
	input  wire logic [30:0]                   control_weight,
	input  wire logic [lqr_pkg::HCNT_W-1:0]    horizon,
	output logic                               done,
	output lqr_pkg::q_t                        dt,
	output lqr_pkg::q_t                        h,
	output lqr_pkg::gain_wr_t                  gain_wr
);
	import lqr_pkg::*;

	typedef enum logic [4:0] {
		R_IDLE, R_DD, R_H, R_S0, R_S1, R_S2, R_S3, R_S4, R_S5, R_S6,
		R_DIV1, R_DIV2, R_S7, R_S8, R_S9, R_S10, R_S11, R_S12
	} ric_state_t;

	ric_state_t state_q;
	logic issued_q, done_q;
	logic [HCNT_W-1:0] t_q;
	q_t dt_q, rho_q, h_q, a_q, b_q, c_q, tmp_q;
	q_t m1_q, m2_q, d_q, g2_q, k1_q, k2_q, w_q, na_q, nb_q;
	gain_wr_t wr_q;
	q_t opa, opb, dn, prod, quot;
	logic is_div, mul_start, div_start, mul_done, div_done;

	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			R_DD: begin opa = dt_q; opb = dt_q; end
			R_H: begin opa = tmp_q; opb = Q_HALF; end
			R_S0: begin opa = a_q; opb = h_q; end
			R_S1: begin opa = b_q; opb = dt_q; end
			R_S2: begin opa = b_q; opb = h_q; end
			R_S3: begin opa = c_q; opb = dt_q; end
			R_S4: begin opa = h_q; opb = m1_q; end
			R_S5: begin opa = dt_q; opb = m2_q; end
			R_S6: begin opa = dt_q; opb = m1_q; end
			R_S7: begin opa = a_q; opb = dt_q; end
			R_S8: begin opa = m1_q; opb = k1_q; end
			R_S9: begin opa = m1_q; opb = k2_q; end
			R_S10: begin opa = dt_q; opb = w_q; end
			R_S11: begin opa = b_q; opb = dt_q; end
			R_S12: begin opa = g2_q; opb = k2_q; end
			default: begin opa = '0; opb = '0; end
		endcase
		is_div = (state_q == R_DIV1) || (state_q == R_DIV2);
		dn = (state_q == R_DIV1) ? m1_q : g2_q;
		mul_start = (state_q != R_IDLE) && !is_div && !issued_q;
		div_start = is_div && !issued_q;
	end

	lqr_qmul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(opa), .b(opb), .done(mul_done), .y(prod)
	);

	lqr_qdiv u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(dn), .d(d_q), .done(div_done), .y(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			issued_q <= 1'b0;
			done_q <= 1'b0;
			wr_q.en <= 1'b0;
		end else begin
			done_q <= 1'b0;
			wr_q.en <= 1'b0;
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end
			if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end
			case (state_q)
				R_IDLE: begin
					if (start) begin
						dt_q <= q_t'({17'h0, step_time, 16'h0});
						rho_q <= q_t'({17'h0, control_weight, 16'h0});
						t_q <= horizon;
						a_q <= Q_ONE;
						b_q <= '0;
						c_q <= '0;
						state_q <= R_DD;
					end
				end
				R_DD: if (mul_done) begin tmp_q <= prod; state_q <= R_H; end
				R_H: if (mul_done) begin h_q <= prod; state_q <= R_S0; end
				R_S0: if (mul_done) begin tmp_q <= prod; state_q <= R_S1; end
				R_S1: if (mul_done) begin m1_q <= sadd(tmp_q, prod); state_q <= R_S2; end
				R_S2: if (mul_done) begin tmp_q <= prod; state_q <= R_S3; end
				R_S3: if (mul_done) begin m2_q <= sadd(tmp_q, prod); state_q <= R_S4; end
				R_S4: if (mul_done) begin tmp_q <= prod; state_q <= R_S5; end
				R_S5: begin
					if (mul_done) begin
						d_q <= sadd(rho_q, sadd(tmp_q, prod));
						state_q <= R_S6;
					end
				end
				R_S6: if (mul_done) begin g2_q <= sadd(prod, m2_q); state_q <= R_DIV1; end
				R_DIV1: if (div_done) begin k1_q <= quot; state_q <= R_DIV2; end
				R_DIV2: if (div_done) begin k2_q <= quot; state_q <= R_S7; end
				R_S7: if (mul_done) begin w_q <= sadd(prod, b_q); state_q <= R_S8; end
				R_S8: begin
					if (mul_done) begin
						na_q <= ssub(sadd(Q_ONE, a_q), prod);
						state_q <= R_S9;
					end
				end
				R_S9: if (mul_done) begin nb_q <= ssub(w_q, prod); state_q <= R_S10; end
				R_S10: if (mul_done) begin tmp_q <= prod; state_q <= R_S11; end
				R_S11: if (mul_done) begin tmp_q <= sadd(tmp_q, prod); state_q <= R_S12; end
				R_S12: begin
					if (mul_done) begin
						// close the step: advance P and drop the gains for step t-1
						c_q <= ssub(sadd(tmp_q, c_q), prod);
						a_q <= na_q;
						b_q <= nb_q;
						wr_q.en <= 1'b1;
						wr_q.addr <= HIDX_W'(t_q - HCNT_W'(1));
						wr_q.nk1 <= ssub('0, k1_q);
						wr_q.nk2 <= ssub('0, k2_q);
						if (t_q == HCNT_W'(1)) begin
							done_q <= 1'b1;
							state_q <= R_IDLE;
						end else begin
							t_q <= t_q - HCNT_W'(1);
							state_q <= R_S0;
						end
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign dt = dt_q;
	assign h = h_q;
	assign gain_wr = wr_q;

endmodule
`default_nettype wire

FILE: rtl/core/lqr_point_mass_trajectory.sv
// Top level of the finite-horizon LQR point-mass trajectory generator.
// Usage:
//   Configuration: write step_time (index 0), control_weight (1) and horizon_steps (2)
//   through cfg_wr_en/cfg_index/cfg_data while the block is idle. Any such write marks
//   the cached gains stale; index 3 is ignored.
//   Input channel: one transaction carries the initial and target state. in_stall is
//   low only while the block is idle, so one request is worked at a time.
//   Output channel: N transactions per request (N = horizon_steps clamped to 1..64),
//   each the state after step t, with step_index = t and last_step on the final one.
//   Gains: the first request after reset or after a configuration write runs the
//   backward Riccati pass on one shared multiplier and divider, with two divisions
//   and thirteen multiplies per horizon step.
//   Rollout: three axis lanes run side by side, each with its own multi-cycle
//   multiplier; a step is a gain memory read and then five multiplies in
//   sequence, and the merge stage writes the joined state to the output
//   register. The next step proceeds while that register waits on out_stall.
//   Reset: asynchronous, clears control state and the gain valid flag; the gain
//   memory needs no clearing because it is always written before it is read.
//   A stalled output holds its transaction; the next result waits until it is taken.
`default_nettype none
module lqr_point_mass_trajectory (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] init_pos_x,
	input  wire logic [31:0] init_pos_y,
	input  wire logic [31:0] init_pos_z,
	input  wire logic [31:0] init_vel_x,
	input  wire logic [31:0] init_vel_y,
	input  wire logic [31:0] init_vel_z,
	input  wire logic [31:0] target_pos_x,
	input  wire logic [31:0] target_pos_y,
	input  wire logic [31:0] target_pos_z,
	input  wire logic [31:0] target_vel_x,
	input  wire logic [31:0] target_vel_y,
	input  wire logic [31:0] target_vel_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_pos_x,
	output logic [31:0]      out_pos_y,
	output logic [31:0]      out_pos_z,
	output logic [31:0]      out_vel_x,
	output logic [31:0]      out_vel_y,
	output logic [31:0]      out_vel_z,
	output logic [5:0]       step_index,
	output logic             last_step
);
	import lqr_pkg::*;

	typedef enum logic [2:0] {T_IDLE, T_GAIN, T_RD, T_WAIT, T_RUN, T_PUSH} top_state_t;

	top_state_t state_q;
	logic [30:0] step_time_q, control_weight_q;
	logic [6:0] horizon_q;
	logic gains_valid_q;
	logic [HIDX_W-1:0] t_q;
	logic [HCNT_W-1:0] n_eff;

	// Gain memory: {-k1, -k2} per step, written by the Riccati pass
	logic [127:0] gain_mem [MAX_HORIZON];
	logic [127:0] gain_rd_s1;

	logic in_acc, rc_start, rc_done, lane_go, is_last, push;
	q_t dt, h;
	gain_wr_t gain_wr;

	q_t lane_ip [3], lane_iv [3], lane_tp [3], lane_tv [3], lane_p [3], lane_v [3];
	logic [2:0] lane_done;

	logic out_valid_q, last_q;
	logic [31:0] pos_q [3], vel_q [3];
	logic [5:0] step_q;

	always_comb begin
		// clamp the horizon into 1..MAX_HORIZON
		if (horizon_q == '0) begin
			n_eff = HCNT_W'(1);
		end else if (horizon_q > 7'(MAX_HORIZON)) begin
			n_eff = HCNT_W'(MAX_HORIZON);
		end else begin
			n_eff = HCNT_W'(horizon_q);
		end
		in_stall = (state_q != T_IDLE);
		in_acc = in_valid && (state_q == T_IDLE);
		rc_start = in_acc && !gains_valid_q;
		lane_go = (state_q == T_WAIT);
		is_last = ({1'b0, t_q} == n_eff - HCNT_W'(1));
		push = (state_q == T_PUSH) && (!out_valid_q || !out_stall);
		lane_ip[0] = port_in(init_pos_x);
		lane_ip[1] = port_in(init_pos_y);
		lane_ip[2] = port_in(init_pos_z);
		lane_iv[0] = port_in(init_vel_x);
		lane_iv[1] = port_in(init_vel_y);
		lane_iv[2] = port_in(init_vel_z);
		lane_tp[0] = port_in(target_pos_x);
		lane_tp[1] = port_in(target_pos_y);
		lane_tp[2] = port_in(target_pos_z);
		lane_tv[0] = port_in(target_vel_x);
		lane_tv[1] = port_in(target_vel_y);
		lane_tv[2] = port_in(target_vel_z);
	end

	lqr_riccati u_riccati (
		.clk(clk), .arst_n(arst_n), .start(rc_start),
		.step_time(step_time_q), .control_weight(control_weight_q),
		.horizon(n_eff), .done(rc_done), .dt(dt), .h(h), .gain_wr(gain_wr)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		lqr_lane u_lane (
			.clk(clk), .arst_n(arst_n), .load(in_acc),
			.init_p(lane_ip[i]), .init_v(lane_iv[i]),
			.tgt_p(lane_tp[i]), .tgt_v(lane_tv[i]),
			.go(lane_go), .nk1(q_t'(gain_rd_s1[127:64])), .nk2(q_t'(gain_rd_s1[63:0])),
			.dt(dt), .h(h), .done(lane_done[i]), .pos(lane_p[i]), .vel(lane_v[i])
		);
	end

	// Gain memory: one write port from the Riccati pass, one registered read port
	always_ff @(posedge clk) begin
		if (gain_wr.en) begin
			gain_mem[gain_wr.addr] <= {gain_wr.nk1, gain_wr.nk2};
		end
		if (state_q == T_RD) begin
			gain_rd_s1 <= gain_mem[t_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			step_time_q <= 31'd655;
			control_weight_q <= 31'd65536;
			horizon_q <= 7'd64;
			gains_valid_q <= 1'b0;
			t_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// configuration: any known register write makes the gains stale
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_STEP_TIME: begin
						step_time_q <= cfg_data;
						gains_valid_q <= 1'b0;
					end
					CFG_CONTROL_WEIGHT: begin
						control_weight_q <= cfg_data;
						gains_valid_q <= 1'b0;
					end
					CFG_HORIZON_STEPS: begin
						horizon_q <= cfg_data[6:0];
						gains_valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						t_q <= '0;
						state_q <= gains_valid_q ? T_RD : T_GAIN;
					end
				end
				T_GAIN: begin
					if (rc_done) begin
						gains_valid_q <= 1'b1;
						state_q <= T_RD;
					end
				end
				T_RD: state_q <= T_WAIT;
				T_WAIT: state_q <= T_RUN;
				T_RUN: begin
					if (&lane_done) begin
						state_q <= T_PUSH;
					end
				end
				T_PUSH: begin
					if (push) begin
						// merge the three lanes into one result transaction
						for (int i = 0; i < 3; i++) begin
							pos_q[i] <= port_out(lane_p[i]);
							vel_q[i] <= port_out(lane_v[i]);
						end
						step_q <= t_q;
						last_q <= is_last;
						out_valid_q <= 1'b1;
						if (is_last) begin
							state_q <= T_IDLE;
						end else begin
							t_q <= t_q + HIDX_W'(1);
							state_q <= T_RD;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_pos_x = pos_q[0];
	assign out_pos_y = pos_q[1];
	assign out_pos_z = pos_q[2];
	assign out_vel_x = vel_q[0];
	assign out_vel_y = vel_q[1];
	assign out_vel_z = vel_q[2];
	assign step_index = step_q;
	assign last_step = last_q;

	// The final transaction of a request carries step N-1
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_step) |-> ({1'b0, step_index} == n_eff - HCNT_W'(1)))
		else $error("last_step on wrong step index");

	// The Riccati pass only finishes while the block waits for it
	a_gain_done: assert property (@(posedge clk) disable iff (!arst_n)
		rc_done |-> (state_q == T_GAIN))
		else $error("gain pass finished outside gain phase");

	// Lanes are never started on stale gains
	a_gain_used: assert property (@(posedge clk) disable iff (!arst_n)
		lane_go |-> gains_valid_q)
		else $error("rollout started without valid gains");

endmodule
`default_nettype wire
